/* hw/rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// Bouncing projectile step package
// Shared register indexes, status codes, multiplier request types and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GRAVITY    = 3'd0,
    CFG_CONTACT    = 3'd1,
    CFG_RESTITUTE  = 3'd2,
    CFG_START_X    = 3'd3,
    CFG_START_Y    = 3'd4,
    CFG_START_VX   = 3'd5,
    CFG_START_VY   = 3'd6,
    CFG_START_TIME = 3'd7
  } cfg_reg_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_AIRBORNE = 2'd0,
    STAT_BOUNCED  = 2'd1,
    STAT_STOPPED  = 2'd2
  } status_e;

  // Tags that say which product sits in the multiplier output register.
  typedef enum logic [3:0] {
    PT_NONE = 4'd0,
    PT_LVX  = 4'd1,
    PT_LVY  = 4'd2,
    PT_VXT  = 4'd3,
    PT_GT   = 4'd4,
    PT_VYT  = 4'd5,
    PT_HLO  = 4'd6,
    PT_HHI  = 4'd7,
    PT_REST = 4'd8,
    PT_SQX  = 4'd9,
    PT_SQY  = 4'd10
  } prod_tag_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        neg;
    prod_tag_e   tag;
  } mul_req_t;

  typedef struct packed {
    logic [63:0] prod;
    logic        neg;
    prod_tag_e   tag;
  } mul_rsp_t;

  localparam logic [30:0] GRAVITY_RST   = 31'd642253;
  localparam logic [31:0] CONTACT_RST   = 32'd0;
  localparam logic [16:0] RESTITUTE_RST = 17'd52429;
  localparam logic [31:0] START_POS_RST = 32'd0;
  localparam logic [31:0] START_VEL_RST = 32'd0;
  localparam logic [30:0] START_T_RST   = 31'd0;

endpackage

`default_nettype wire

/* hw/rtl/bouncing_projectile_step.sv */
// ----------------------------------------------------------------------------
// Bouncing projectile step
// Fixed-point ballistic flight with ground bounces, evaluated on one shared
// multiplier under a one-hot sequencer.
// ----------------------------------------------------------------------------
// A new request is taken only in the idle state, which the sequencer reaches
// again once the result is loaded into the output register. A bounce step
// adds the rebound and speed-square states, the first step after reset adds
// the launch speed squares, and a stopped step goes straight to the repeat
// state. Each product of the step passes the single 32 x 32 multiplier in turn.
// Reset: rst_ni is asynchronous, active low; it returns the sequencer to idle,
// loads the register defaults and clears the launched and stopped flags.
`default_nettype none

module bouncing_projectile_step (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration write channel.
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  // Input stream.
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [31:0]  s_axis_tdata_i,   // [30:0] elapsed_time
  // Output stream.
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [31:0] pos_x, [63:32] pos_y, [95:64] vel_x, [127:96] vel_y,
  // [158:128] time_base
  output logic [159:0]      m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o    // [1:0] status
);

  // Sequencer states. Each state issues at most one multiply; the product is
  // consumed in the next cycle, keyed by its tag rather than by the state.
  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_L_SQX = 16'h0002,
    ST_L_SQY = 16'h0004,
    ST_VX    = 16'h0008,
    ST_GT    = 16'h0010,
    ST_VY    = 16'h0020,
    ST_HLO   = 16'h0040,
    ST_HHI   = 16'h0080,
    ST_H     = 16'h0100,
    ST_Y     = 16'h0200,
    ST_CHK   = 16'h0400,
    ST_SQX   = 16'h0800,
    ST_SQY   = 16'h1000,
    ST_CMP   = 16'h2000,
    ST_DEC   = 16'h4000,
    ST_HALT  = 16'h8000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -52'sd2147483648) begin
      return -32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  state_e state_q, state_d;

  // Configuration registers.
  logic        [30:0] gravity_q;
  logic signed [31:0] contact_q;
  logic        [16:0] rest_q;
  logic        [31:0] start_x_q, start_y_q, start_vx_q, start_vy_q;
  logic        [30:0] start_t_q;

  // Flight state.
  logic               launched_q, launched_d;
  logic               halted_q, halted_d;
  logic signed [31:0] seg_x_q, seg_x_d, seg_y_q, seg_y_d;
  logic signed [31:0] seg_vx_q, seg_vx_d, seg_vy_q, seg_vy_d;
  logic        [30:0] time_acc_q, time_acc_d;
  logic        [63:0] rhs_q, rhs_d;

  // Per-step working registers.
  logic        [30:0] t_q, t_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, vy_q, vy_d;
  logic        [45:0] gt_q, gt_d;
  logic signed [49:0] yp_q, yp_d;
  logic        [63:0] hlo_q, hlo_d;
  logic        [48:0] h_q, h_d;
  logic        [63:0] lhs_q, lhs_d;

  // Output register, which also keeps the last result for the stopped state.
  logic               m_valid_q, m_valid_d;
  logic signed [31:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic signed [31:0] out_vx_q, out_vx_d, out_vy_q, out_vy_d;
  logic        [30:0] out_t_q, out_t_d;
  bps_pkg::status_e   out_st_q, out_st_d;

  bps_pkg::mul_req_t  mul_req;
  bps_pkg::mul_rsp_t  mul_rsp;

  logic               in_take;
  logic               out_free;
  logic signed [64:0] sp_full;
  logic signed [64:0] sp_sum;
  logic signed [48:0] sp_rnd;
  logic        [77:0] h_full;
  logic        [63:0] h_sum;
  logic        [31:0] t_sum;
  logic        [30:0] t_next;
  logic        [68:0] lhs20;
  logic               bounce;
  logic               stop;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  // A new result may be loaded when the output register is empty or draining.
  assign out_free        = !m_valid_q || m_axis_tready_i;

  bps_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // Signed product rounded half up to Q16.16 (floor of value plus half LSB).
  assign sp_full = mul_rsp.neg ? -$signed({1'b0, mul_rsp.prod})
                               : $signed({1'b0, mul_rsp.prod});
  assign sp_sum  = sp_full + 65'sd32768;
  assign sp_rnd  = sp_sum[64:16];

  // g*t*t/2 from the two partial products of round(g*t) and t. Anything that
  // would not fit a signed 64-bit intermediate takes the capped value.
  assign h_full = {mul_rsp.prod[45:0], 32'd0} + {14'd0, hlo_q};
  assign h_sum  = {1'b0, h_full[62:0]} + 64'h10000;

  assign t_sum  = {1'b0, time_acc_q} + {1'b0, t_q};
  assign t_next = t_sum[31] ? '1 : t_sum[30:0];

  // Stop when twenty times the bounce speed square is below the launch one.
  assign lhs20  = {1'b0, lhs_q, 4'd0} + {3'd0, lhs_q, 2'd0};
  assign stop   = lhs20 < {5'd0, rhs_q};
  assign bounce = (y_q < contact_q) && vy_q[31];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q  <= bps_pkg::GRAVITY_RST;
      contact_q  <= bps_pkg::CONTACT_RST;
      rest_q     <= bps_pkg::RESTITUTE_RST;
      start_x_q  <= bps_pkg::START_POS_RST;
      start_y_q  <= bps_pkg::START_POS_RST;
      start_vx_q <= bps_pkg::START_VEL_RST;
      start_vy_q <= bps_pkg::START_VEL_RST;
      start_t_q  <= bps_pkg::START_T_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bps_pkg::cfg_reg_e'(cfg_index_i))
        bps_pkg::CFG_GRAVITY:    gravity_q  <= cfg_data_i[30:0];
        bps_pkg::CFG_CONTACT:    contact_q  <= cfg_data_i;
        bps_pkg::CFG_RESTITUTE:  rest_q     <= cfg_data_i[16:0];
        bps_pkg::CFG_START_X:    start_x_q  <= cfg_data_i;
        bps_pkg::CFG_START_Y:    start_y_q  <= cfg_data_i;
        bps_pkg::CFG_START_VX:   start_vx_q <= cfg_data_i;
        bps_pkg::CFG_START_VY:   start_vy_q <= cfg_data_i;
        bps_pkg::CFG_START_TIME: start_t_q  <= cfg_data_i[30:0];
      endcase
    end
  end

  // Multiply issue, keyed by state.
  always_comb begin
    mul_req     = '0;
    mul_req.tag = bps_pkg::PT_NONE;
    unique case (state_q)
      ST_L_SQX: begin
        mul_req.a   = abs32(seg_vx_q);
        mul_req.b   = abs32(seg_vx_q);
        mul_req.tag = bps_pkg::PT_LVX;
      end
      ST_L_SQY: begin
        mul_req.a   = abs32(seg_vy_q);
        mul_req.b   = abs32(seg_vy_q);
        mul_req.tag = bps_pkg::PT_LVY;
      end
      ST_VX: begin
        mul_req.a   = abs32(seg_vx_q);
        mul_req.b   = {1'b0, t_q};
        mul_req.neg = seg_vx_q[31];
        mul_req.tag = bps_pkg::PT_VXT;
      end
      ST_GT: begin
        mul_req.a   = {1'b0, gravity_q};
        mul_req.b   = {1'b0, t_q};
        mul_req.tag = bps_pkg::PT_GT;
      end
      ST_VY: begin
        mul_req.a   = abs32(seg_vy_q);
        mul_req.b   = {1'b0, t_q};
        mul_req.neg = seg_vy_q[31];
        mul_req.tag = bps_pkg::PT_VYT;
      end
      ST_HLO: begin
        mul_req.a   = gt_q[31:0];
        mul_req.b   = {1'b0, t_q};
        mul_req.tag = bps_pkg::PT_HLO;
      end
      ST_HHI: begin
        mul_req.a   = {18'd0, gt_q[45:32]};
        mul_req.b   = {1'b0, t_q};
        mul_req.tag = bps_pkg::PT_HHI;
      end
      ST_CHK: begin
        // The rebound speed is the magnitude of a falling velocity.
        if (bounce) begin
          mul_req.a   = abs32(vy_q);
          mul_req.b   = {15'd0, rest_q};
          mul_req.tag = bps_pkg::PT_REST;
        end
      end
      ST_SQX: begin
        mul_req.a   = abs32(seg_vx_q);
        mul_req.b   = abs32(seg_vx_q);
        mul_req.tag = bps_pkg::PT_SQX;
      end
      ST_SQY: begin
        mul_req.a   = vy_q;
        mul_req.b   = vy_q;
        mul_req.tag = bps_pkg::PT_SQY;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, product consumption and result loading.
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    halted_d   = halted_q;
    seg_x_d    = seg_x_q;
    seg_y_d    = seg_y_q;
    seg_vx_d   = seg_vx_q;
    seg_vy_d   = seg_vy_q;
    time_acc_d = time_acc_q;
    rhs_d      = rhs_q;
    t_d        = t_q;
    x_d        = x_q;
    y_d        = y_q;
    vy_d       = vy_q;
    gt_d       = gt_q;
    yp_d       = yp_q;
    hlo_d      = hlo_q;
    h_d        = h_q;
    lhs_d      = lhs_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_vx_d   = out_vx_q;
    out_vy_d   = out_vy_q;
    out_t_d    = out_t_q;
    out_st_d   = out_st_q;

    case (mul_rsp.tag)
      bps_pkg::PT_LVX:  rhs_d = mul_rsp.prod;
      bps_pkg::PT_LVY:  rhs_d = rhs_q + mul_rsp.prod;
      bps_pkg::PT_VXT:  x_d   = sat32(52'(seg_x_q) + 52'(sp_rnd));
      bps_pkg::PT_GT:   gt_d  = sp_rnd[45:0];
      bps_pkg::PT_VYT:  yp_d  = 50'(seg_y_q) + 50'(sp_rnd);
      bps_pkg::PT_HLO:  hlo_d = mul_rsp.prod;
      bps_pkg::PT_HHI:  h_d   = (h_full[77:63] != '0) ? 49'h1_0000_0000_0000
                                                      : {2'd0, h_sum[63:17]};
      bps_pkg::PT_REST: vy_d  = sat32(52'(sp_rnd));
      bps_pkg::PT_SQX:  lhs_d = mul_rsp.prod;
      bps_pkg::PT_SQY:  lhs_d = lhs_q + mul_rsp.prod;
      default: begin
      end
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          t_d = s_axis_tdata_i[30:0];
          if (halted_q) begin
            state_d = ST_HALT;
          end else if (!launched_q) begin
            // First request after reset latches the launch registers.
            launched_d = 1'b1;
            seg_x_d    = start_x_q;
            seg_y_d    = start_y_q;
            seg_vx_d   = start_vx_q;
            seg_vy_d   = start_vy_q;
            time_acc_d = start_t_q;
            state_d    = ST_L_SQX;
          end else begin
            state_d = ST_VX;
          end
        end
      end
      ST_L_SQX: state_d = ST_L_SQY;
      ST_L_SQY: state_d = ST_VX;
      ST_VX:    state_d = ST_GT;
      ST_GT:    state_d = ST_VY;
      ST_VY:    state_d = ST_HLO;
      ST_HLO:   state_d = ST_HHI;
      ST_HHI: begin
        vy_d    = sat32($signed(52'(seg_vy_q)) - $signed({6'd0, gt_q}));
        state_d = ST_H;
      end
      ST_H:     state_d = ST_Y;
      ST_Y: begin
        y_d     = sat32(52'(yp_q) - $signed({3'd0, h_q}));
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (bounce) begin
          state_d = ST_SQX;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          out_x_d   = x_q;
          out_y_d   = y_q;
          out_vx_d  = seg_vx_q;
          out_vy_d  = vy_q;
          out_t_d   = time_acc_q;
          out_st_d  = bps_pkg::STAT_AIRBORNE;
          state_d   = ST_IDLE;
        end
      end
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_CMP;
      ST_CMP:   state_d = ST_DEC;
      ST_DEC: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          out_x_d   = x_q;
          out_y_d   = y_q;
          out_vx_d  = seg_vx_q;
          out_vy_d  = vy_q;
          if (stop) begin
            halted_d = 1'b1;
            out_t_d  = time_acc_q;
            out_st_d = bps_pkg::STAT_STOPPED;
          end else begin
            // The next segment starts at the bounce point.
            seg_x_d    = x_q;
            seg_y_d    = y_q;
            seg_vy_d   = vy_q;
            time_acc_d = t_next;
            out_t_d    = t_next;
            out_st_d   = bps_pkg::STAT_BOUNCED;
          end
          state_d = ST_IDLE;
        end
      end
      ST_HALT: begin
        // Stopped: repeat the held result with the stopped status.
        if (out_free) begin
          m_valid_d = 1'b1;
          out_st_d  = bps_pkg::STAT_STOPPED;
          state_d   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
      halted_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      halted_q   <= halted_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_x_q    <= seg_x_d;
    seg_y_q    <= seg_y_d;
    seg_vx_q   <= seg_vx_d;
    seg_vy_q   <= seg_vy_d;
    time_acc_q <= time_acc_d;
    rhs_q      <= rhs_d;
    t_q        <= t_d;
    x_q        <= x_d;
    y_q        <= y_d;
    vy_q       <= vy_d;
    gt_q       <= gt_d;
    yp_q       <= yp_d;
    hlo_q      <= hlo_d;
    h_q        <= h_d;
    lhs_q      <= lhs_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_vx_q   <= out_vx_d;
    out_vy_q   <= out_vy_d;
    out_t_q    <= out_t_d;
    out_st_q   <= out_st_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_t_q, out_vy_q, out_vx_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_st_q;

  // Once stopped, the flight never resumes until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("stopped flag cleared without reset");

  // A request taken while stopped goes straight to the repeat state.
  a_halt_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && halted_q) |=> (state_q == ST_HALT))
    else $error("stopped request did not take the repeat path");

  // A rebound always leaves the ball moving upward or at rest.
  a_bounce_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_st_q == bps_pkg::STAT_BOUNCED) |-> !out_vy_q[31])
    else $error("bounced result with a falling velocity");

  // No product is ever left in flight when the sequencer returns to idle.
  a_no_stray_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_rsp.tag != bps_pkg::PT_NONE) |-> (state_q != ST_IDLE))
    else $error("multiplier product pending while idle");

  // Airborne or bounced results only come after launch.
  a_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> launched_q)
    else $error("result produced before launch");

endmodule

`default_nettype wire

/* hw/rtl/bps_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32 x 32 unsigned multiply per cycle with a registered product. The sign
// flag and the tag of the request travel along with the product.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bps_pkg::mul_req_t req_i,
  output bps_pkg::mul_rsp_t      rsp_o
);

  logic [63:0] prod_d;
  logic [63:0] prod_q;
  logic        neg_q;
  bps_pkg::prod_tag_e tag_q;

  assign prod_d = req_i.a * req_i.b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= req_i.neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= bps_pkg::PT_NONE;
    end else begin
      tag_q <= req_i.tag;
    end
  end

  assign rsp_o.prod = prod_q;
  assign rsp_o.neg  = neg_q;
  assign rsp_o.tag  = tag_q;

endmodule

`default_nettype wire

/* dv/bouncing_projectile_step_tb.sv */
// ----------------------------------------------------------------------------
// Bouncing projectile step testbench
// Drives elapsed-time requests into the block and checks every result against
// a fixed-point flight predictor kept inside this file. The run covers launch,
// plain flight, bounces, saturation, ignored late launch writes, restitution
// above one and the final stop. Both stream sides idle at random, and the
// output side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module bouncing_projectile_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          MAX_PRINTED   = 50;

  localparam longint I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint TERM_CAP = 64'sh0001_0000_0000_0000;
  localparam longint MAX31    = 64'sh0000_0000_7FFF_FFFF;

  // Clock, reset and every block input start at known values.
  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         cfg_valid_i     = 1'b0;
  logic [2:0]   cfg_index_i     = '0;
  logic [31:0]  cfg_data_i      = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic [31:0]  s_axis_tdata_i  = '0;
  logic         m_axis_tready_i = 1'b0;
  logic         cfg_ready_o;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [159:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  bouncing_projectile_step dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // One expected result: position, velocity, time base and status.
  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [30:0] time_base;
    status_e     status;
  } sample_t;

  // Flight state as the predictor tracks it. The last_* fields hold the most
  // recent position and velocity, which a stopped ball keeps repeating.
  typedef struct {
    bit     launched;
    bit     halted;
    longint seg_x, seg_y, seg_vx, seg_vy, time_acc;
    longint launch_vx, launch_vy;
    longint last_x, last_y, last_vx, last_vy;
  } flight_t;

  // Register copies, loaded with the reset values of the package.
  logic [30:0]        gravity_r     = GRAVITY_RST;
  logic signed [31:0] contact_r     = CONTACT_RST;
  logic [16:0]        restitution_r = RESTITUTE_RST;
  logic signed [31:0] start_x_r     = START_POS_RST;
  logic signed [31:0] start_y_r     = START_POS_RST;
  logic signed [31:0] start_vx_r    = START_VEL_RST;
  logic signed [31:0] start_vy_r    = START_VEL_RST;
  logic [30:0]        start_time_r  = START_T_RST;

  flight_t     flight;
  sample_t     expected_samples[$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Idle rates in percent for the sender and the receiver, and the request
  // for one long receiver hold-off.
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  bit hold_request  = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Flight predictor
  // ---------------------------------------------------------------------------

  // Round a Q.32 product to Q16.16, half up.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic [63:0] square_mag(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic sample_t snapshot(input flight_t s, input status_e st);
    sample_t r;
    r.pos_x     = 32'(s.last_x);
    r.pos_y     = 32'(s.last_y);
    r.vel_x     = 32'(s.last_vx);
    r.vel_y     = 32'(s.last_vy);
    r.time_base = 31'(s.time_acc);
    r.status    = st;
    return r;
  endfunction

  // Works out the result of one step and returns the flight state after it.
  function automatic flight_t advance_flight(input flight_t s, input logic [30:0] dt,
                                             output sample_t r);
    longint      t, g, rest, contact, x, y, vx, vy, gt, h;
    logic [63:0] p, lhs, rhs;
    status_e     st;
    st = STAT_AIRBORNE;
    if (s.halted) begin
      r = snapshot(s, STAT_STOPPED);
      return s;
    end
    // The first step after reset latches the launch registers; later writes
    // to them have no effect on this flight.
    if (!s.launched) begin
      s.seg_x     = start_x_r;
      s.seg_y     = start_y_r;
      s.seg_vx    = start_vx_r;
      s.seg_vy    = start_vy_r;
      s.launch_vx = s.seg_vx;
      s.launch_vy = s.seg_vy;
      s.time_acc  = start_time_r;
      s.launched  = 1'b1;
    end
    t       = dt;
    g       = gravity_r;
    rest    = restitution_r;
    contact = contact_r;

    vx = s.seg_vx;
    x  = clamp32(s.seg_x + round_q16(s.seg_vx * t));
    gt = round_q16(g * t);
    vy = clamp32(s.seg_vy - gt);
    // The drop term g*t*t/2 is built from the rounded g*t and capped at 2^48,
    // which always pins the height at its minimum.
    if (t != 0 && gt > I64_MAX / t) begin
      h = TERM_CAP;
    end else begin
      p = gt * t;
      p = p + 64'h1_0000;
      h = p >> 17;
      if (h > TERM_CAP) h = TERM_CAP;
    end
    y = clamp32(s.seg_y + round_q16(s.seg_vy * t) - h);

    if (y < contact && vy < 0) begin
      vy  = clamp32(round_q16(-vy * rest));
      lhs = square_mag(vx) + square_mag(vy);
      rhs = square_mag(s.launch_vx) + square_mag(s.launch_vy);
      // Stop once the squared speed falls under a twentieth of the launch one.
      // A stop leaves the segment and the time base as they were.
      if (lhs < (rhs + 64'd19) / 64'd20) begin
        s.halted = 1'b1;
        st       = STAT_STOPPED;
      end else begin
        s.seg_x    = x;
        s.seg_y    = y;
        s.seg_vx   = vx;
        s.seg_vy   = vy;
        s.time_acc = s.time_acc + t;
        if (s.time_acc > MAX31) s.time_acc = MAX31;
        st = STAT_BOUNCED;
      end
    end

    s.last_x  = x;
    s.last_y  = y;
    s.last_vx = vx;
    s.last_vy = vy;
    r = snapshot(s, st);
    return s;
  endfunction

  // Draws an elapsed time. Small times dominate so that flights and bounces
  // stay in range; full-width draws push fields into saturation. Unless a
  // stop is wanted, draws that would stop the ball are thrown away. Every
  // segment starts with a nonnegative vertical speed (the launch speed is
  // upward and a bounce never points down), so a zero time never bounces and
  // serves as the fallback.
  function automatic logic [30:0] pick_elapsed(input bit allow_stop);
    logic [30:0] dt;
    sample_t     unused;
    flight_t     trial;
    for (int i = 0; i < 32; i++) begin
      case ($urandom_range(9))
        0:       dt = 31'($urandom_range(255));
        1:       dt = 31'($urandom);
        2, 3:    dt = 31'($urandom_range(32'h000F_FFFF));
        default: dt = 31'($urandom_range(32'h0003_FFFF));
      endcase
      trial = advance_flight(flight, dt, unused);
      if (allow_stop || flight.halted || !trial.halted) return dt;
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Writes one register and updates the predictor's copy at acceptance. The
  // valid stays high so that back-to-back writes never drop it within a step;
  // the callers lower it after their last write.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GRAVITY:    gravity_r     = val[30:0];
      CFG_CONTACT:    contact_r     = val;
      CFG_RESTITUTE:  restitution_r = val[16:0];
      CFG_START_X:    start_x_r     = val;
      CFG_START_Y:    start_y_r     = val;
      CFG_START_VX:   start_vx_r    = val;
      CFG_START_VY:   start_vy_r    = val;
      CFG_START_TIME: start_time_r  = val[30:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [30:0] g, input logic [31:0] contact,
                                input logic [16:0] rest);
    write_reg(CFG_GRAVITY, {1'b0, g});
    write_reg(CFG_CONTACT, contact);
    write_reg(CFG_RESTITUTE, {15'd0, rest});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_launch(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] vx, input logic [31:0] vy,
                              input logic [30:0] t0);
    write_reg(CFG_START_X, x);
    write_reg(CFG_START_Y, y);
    write_reg(CFG_START_VX, vx);
    write_reg(CFG_START_VY, vy);
    write_reg(CFG_START_TIME, {1'b0, t0});
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one elapsed-time request, after a random gap, and records the
  // expected result once the block takes it.
  task automatic send_step(input logic [30:0] dt);
    sample_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, dt};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    flight = advance_flight(flight, dt, r);
    expected_samples.push_back(r);
  endtask

  // Stops offering, waits for every expected result, then lets the block's
  // pipeline run dry so that a register write lands on an idle block.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // The receiver stalls at the current idle rate. On a hold-off request it
  // keeps tready low for a long stretch, counted here, while the sender goes
  // on offering requests and the block backs up.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %h expected %h", name, got, exp));
  endtask

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    sample_t exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp = expected_samples.pop_front();
        check_field("pos_x", m_axis_tdata_o[31:0], exp.pos_x);
        check_field("pos_y", m_axis_tdata_o[63:32], exp.pos_y);
        check_field("vel_x", m_axis_tdata_o[95:64], exp.vel_x);
        check_field("vel_y", m_axis_tdata_o[127:96], exp.vel_y);
        check_field("time_base", {1'b0, m_axis_tdata_o[158:128]}, {1'b0, exp.time_base});
        check_field("status", {30'd0, m_axis_tuser_o}, {30'd0, exp.status});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Launch from (-100, 50) with velocity (1, 5) and time base 1000. The first
  // request latches these; the short times check rounding at half an LSB, the
  // longer ones carry the ball through the ground.
  task automatic test_launch_and_first_flight();
    logic [30:0] steps [11] = '{31'd0, 31'd1, 31'h7FFF, 31'h8000, 31'h1_0000,
                                31'h2_0000, 31'h3_0000, 31'h4_0000, 31'd0,
                                31'h4000, 31'h5_0000};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(GRAVITY_RST, CONTACT_RST, RESTITUTE_RST);
    apply_launch(32'hFF9C_0000, 32'h0032_0000, 32'h0001_0000, 32'h0005_0000,
                 31'h03E8_0000);
    foreach (steps[i]) send_step(steps[i]);
    settle();
  endtask

  // Launch registers written after launch, at their extremes, must change
  // nothing in the running flight.
  task automatic test_late_start_writes();
    apply_launch(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF);
    send_step(31'h1_0000);
    send_step(31'h3_0000);
    settle();
  endtask

  // The largest restitution, almost two, is used as written.
  task automatic test_restitution_above_one();
    apply_settings(GRAVITY_RST, CONTACT_RST, 17'h1_FFFF);
    send_step(31'h4_0000);
    send_step(31'h6_0000);
    send_step(31'h8000);
    settle();
  endtask

  // No gravity with the lowest contact height never bounces; the largest
  // gravity and contact height with the longest time drive the drop term to
  // its cap and the height and the vertical speed into saturation.
  task automatic test_gravity_and_contact_extremes();
    apply_settings(31'd0, 32'h8000_0000, 17'h1_0000);
    send_step(31'h1_0000);
    send_step(31'h7FFF_FFFF);
    settle();
    apply_settings(31'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1_0000);
    send_step(31'd1);
    send_step(31'h7FFF_FFFF);
    settle();
  endtask

  task automatic test_random_flight(input int tx_pct, input int rx_pct,
                                    input logic [30:0] g, input logic [31:0] contact,
                                    input logic [16:0] rest, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    apply_settings(g, contact, rest);
    repeat (count) send_step(pick_elapsed(1'b0));
    settle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    repeat (25) send_step(pick_elapsed(1'b0));
    settle();
  endtask

  // With no restitution and the highest contact height, the next bounce leaves
  // only the horizontal speed, under the stop threshold for this launch. Every
  // request after that repeats the last result with the stopped status.
  task automatic test_stop_and_hold();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    apply_settings(GRAVITY_RST, 32'h7FFF_FFFF, 17'd0);
    repeat (30) send_step(pick_elapsed(1'b1));
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_launch_and_first_flight();
    test_late_start_writes();
    test_restitution_above_one();
    test_gravity_and_contact_extremes();
    // Earthlike gravity on flat ground; sender busy, receiver slow.
    test_random_flight(10, 57, GRAVITY_RST, 32'h0, 17'h1_0000, 330);
    // Any gravity and contact height; sender slow, receiver busy.
    test_random_flight(57, 10, 31'($urandom), 32'($urandom),
                       17'($urandom_range(32768, 131071)), 330);
    // Moderate gravity, contact within 100 of zero; no idling at all.
    test_random_flight(0, 0, 31'($urandom_range(1, 32'h0010_0000)),
                       32'($urandom_range(0, 32'h00C8_0000)) - 32'h0064_0000,
                       17'($urandom_range(32768, 131071)), 340);
    test_output_backpressure();
    test_stop_and_hold();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bps_pkg.sv
hw/rtl/bps_mul.sv
hw/rtl/bouncing_projectile_step.sv
dv/bouncing_projectile_step_tb.sv
